// ===== rtl/core/sstfw_pkg.sv =====
// ----------------------------------------------------------------------------
// sstfw_pkg
// Types, constants and the glyph table for the seven-segment text frame writer.
// ----------------------------------------------------------------------------
package sstfw_pkg;

  localparam int DIGITS_DEFAULT = 6;

  localparam int CMD_W  = 2;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  // command codes (tuser of the input stream)
  localparam logic [CMD_W-1:0] CMD_PUT     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REFRESH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_DISPLAY_CONTROL = 3'd0;
  localparam logic [CFG_IW-1:0] REG_POSITION_REMAP  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_DOT_MASK        = 3'd2;
  localparam logic [CFG_IW-1:0] REG_DATA_COMMAND    = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ADDRESS_COMMAND = 3'd4;
  localparam logic [CFG_IW-1:0] REG_CONTROL_COMMAND = 3'd5;

  // reset values
  localparam logic [3:0]  RST_DISPLAY_CONTROL = 4'hf;
  localparam logic [31:0] RST_POSITION_REMAP  = 32'h7834_5012;
  localparam logic [7:0]  RST_DOT_MASK        = 8'h80;
  localparam logic [7:0]  RST_DATA_COMMAND    = 8'h40;
  localparam logic [7:0]  RST_ADDRESS_COMMAND = 8'hc0;
  localparam logic [7:0]  RST_CONTROL_COMMAND = 8'h80;

  localparam logic [7:0] CHAR_PERIOD = 8'h2e;

  localparam logic [7:0] GLYPH [17] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
    8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'hff
  };

  // '0'..'9' -> 0..9, letters case-blind from 'a', above 'f' all-on, folded codes below 87 clamp to 0
  function automatic logic [7:0] glyph_of(input logic [7:0] code);
    logic [7:0] folded;
    logic [4:0] idx;
    if (code >= 8'h30 && code <= 8'h39) begin
      idx = 5'(code - 8'h30);
    end else begin
      folded = (code >= 8'h41 && code <= 8'h5a) ? code + 8'h20 : code;
      if (folded >= 8'd103) begin
        idx = 5'd16;
      end else if (folded < 8'd87) begin
        idx = 5'd0;
      end else begin
        idx = 5'(folded - 8'd87);
      end
    end
    return GLYPH[idx];
  endfunction

endpackage

// ===== rtl/core/seven_segment_text_frame_writer.sv =====
// ----------------------------------------------------------------------------
// seven_segment_text_frame_writer
// Text to seven-segment frame bytes, digit buffer held in a small RAM.
// ----------------------------------------------------------------------------
// Input stream: one transaction per command. tuser is the command (put
// character, clear, refresh); tlast marks the last character of a string.
// A put character passes through the put state, a period that sets a dot
// also through the dot state (read-modify-write of the previous digit through
// the registered RAM read port). Clear, refresh and a last character then
// send a frame of DIGITS+3 bytes on the output stream, one byte per cycle
// while the receiver takes them; the single RAM read port, read one byte
// ahead of the output register, sets the byte rate.
// Output stream: tdata is the bus byte, tuser the start/stop marks, tlast the
// final byte of the frame. A stalled receiver holds the output register and
// the frame sequencer; no new input is taken until the last byte is loaded.
// Reset (synchronous) zeroes the cursor, marks every digit as blank through
// per-digit valid bits and loads the configuration reset values.
// Configuration writes should be made only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module seven_segment_text_frame_writer #(
  parameter int DIGITS = sstfw_pkg::DIGITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // char_code, first_char, start_pos
  input  logic [sstfw_pkg::CMD_W-1:0]   s_axis_tuser,  // command
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // bus_byte
  output logic [1:0]                    m_axis_tuser,  // start_before, stop_after
  output logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [sstfw_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sstfw_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int KW = $clog2(DIGITS + 3);
  localparam logic [3:0]    DIG4     = 4'(DIGITS);
  localparam logic [KW-1:0] K_DLAST  = KW'(DIGITS + 1);
  localparam logic [KW-1:0] K_CTRL   = KW'(DIGITS + 2);
  localparam logic [KW-1:0] K_RDLAST = KW'(DIGITS);

  typedef enum logic [1:0] {ST_IDLE, ST_PUT, ST_DOT, ST_FRAME} state_t;

  state_t state;

  logic [3:0]  display_control;
  logic [31:0] position_remap;
  logic [7:0]  dot_mask;
  logic [7:0]  data_command;
  logic [7:0]  address_command;
  logic [7:0]  control_command;

  logic [3:0]        cursor;
  logic [7:0]        itm_char;
  logic              itm_last;
  logic [AW-1:0]     dot_slot;
  logic [KW-1:0]     k;
  logic [DIGITS-1:0] valid;

  logic [7:0]    mem [DIGITS];
  logic [7:0]    rd_data;
  logic          rd_valid;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    wr_data;
  logic [7:0]    rd_eff;

  logic          s_acc;
  logic          out_free;
  logic [3:0]    slot_cur;
  logic [3:0]    slot_prev;
  logic [2:0]    pos_prev;
  logic [KW-1:0] frame_rd_idx;
  logic          frame_rd;
  logic [7:0]    frame_byte;
  logic [1:0]    frame_marks;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign pos_prev  = cursor[2:0] - 3'd1;
  assign slot_cur  = position_remap[{cursor[2:0], 2'b00} +: 4];
  assign slot_prev = position_remap[{pos_prev, 2'b00} +: 4];
  assign rd_eff    = rd_valid ? rd_data : 8'h00;

  assign frame_rd_idx = k - KW'(1);
  assign frame_rd     = (state == ST_FRAME) && out_free && (k != '0) && (k <= K_RDLAST);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = slot_cur[AW-1:0];
    wr_data = sstfw_pkg::glyph_of(itm_char);
    mem_re  = 1'b0;
    rd_addr = slot_prev[AW-1:0];
    case (state)
      ST_PUT: begin
        if (cursor < DIG4) begin
          if (itm_char == sstfw_pkg::CHAR_PERIOD) begin
            mem_re = (cursor != 4'd0) && (slot_prev < DIG4);
          end else begin
            mem_we = (slot_cur < DIG4);
          end
        end
      end
      ST_DOT: begin
        mem_we  = 1'b1;
        wr_addr = dot_slot;
        wr_data = rd_eff | dot_mask;
      end
      ST_FRAME: begin
        mem_re  = frame_rd;
        rd_addr = frame_rd_idx[AW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    frame_byte  = rd_eff;
    frame_marks = 2'b00;
    if (k == '0) begin
      frame_byte  = data_command;
      frame_marks = 2'b11;
    end else if (k == KW'(1)) begin
      frame_byte  = address_command;
      frame_marks = 2'b01;
    end else if (k == K_CTRL) begin
      frame_byte  = control_command + {4'h0, display_control};
      frame_marks = 2'b11;
    end else if (k == K_DLAST) begin
      frame_marks = 2'b10;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cursor          <= 4'd0;
      valid           <= '0;
      k               <= '0;
      m_axis_tvalid   <= 1'b0;
      display_control <= sstfw_pkg::RST_DISPLAY_CONTROL;
      position_remap  <= sstfw_pkg::RST_POSITION_REMAP;
      dot_mask        <= sstfw_pkg::RST_DOT_MASK;
      data_command    <= sstfw_pkg::RST_DATA_COMMAND;
      address_command <= sstfw_pkg::RST_ADDRESS_COMMAND;
      control_command <= sstfw_pkg::RST_CONTROL_COMMAND;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sstfw_pkg::REG_DISPLAY_CONTROL: display_control <= cfg_data[3:0];
          sstfw_pkg::REG_POSITION_REMAP:  position_remap  <= cfg_data;
          sstfw_pkg::REG_DOT_MASK:        dot_mask        <= cfg_data[7:0];
          sstfw_pkg::REG_DATA_COMMAND:    data_command    <= cfg_data[7:0];
          sstfw_pkg::REG_ADDRESS_COMMAND: address_command <= cfg_data[7:0];
          sstfw_pkg::REG_CONTROL_COMMAND: control_command <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (m_axis_tready && (state != ST_FRAME)) begin
        m_axis_tvalid <= 1'b0;
      end

      if (mem_we) begin
        valid[wr_addr] <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            itm_char <= s_axis_tdata[7:0];
            itm_last <= s_axis_tlast;
            k        <= '0;
            case (s_axis_tuser)
              sstfw_pkg::CMD_PUT: begin
                if (s_axis_tdata[8]) begin
                  cursor <= s_axis_tdata[12:9];
                end
                state <= ST_PUT;
              end
              sstfw_pkg::CMD_CLEAR: begin
                valid <= '0;
                state <= ST_FRAME;
              end
              sstfw_pkg::CMD_REFRESH: state <= ST_FRAME;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_PUT: begin
          if ((cursor < DIG4) && (itm_char != sstfw_pkg::CHAR_PERIOD)) begin
            cursor <= cursor + 4'd1;
          end
          if (mem_re) begin
            dot_slot <= slot_prev[AW-1:0];
            state    <= ST_DOT;
          end else begin
            state <= itm_last ? ST_FRAME : ST_IDLE;
          end
        end
        ST_DOT: begin
          state <= itm_last ? ST_FRAME : ST_IDLE;
        end
        ST_FRAME: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= frame_byte;
            m_axis_tuser  <= frame_marks;
            m_axis_tlast  <= (k == K_CTRL);
            if (k == K_CTRL) begin
              state <= ST_IDLE;
            end else begin
              k <= k + KW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_end_marks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == 2'b11)
    else $error("frame end byte without start and stop marks");

  a_no_input_in_frame: assert property (@(posedge clk) disable iff (rst)
    state == ST_FRAME |-> !s_axis_tready)
    else $error("input taken while a frame is being sent");

  a_clear_blanks: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tuser == sstfw_pkg::CMD_CLEAR |=> valid == '0 && state == ST_FRAME)
    else $error("clear did not blank the buffer before the frame");

  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    state == ST_FRAME && out_free && k == '0 |=> m_axis_tvalid && m_axis_tuser == 2'b11)
    else $error("frame did not open with the data command");

endmodule

// ===== tb/frame_checker.sv =====
// ----------------------------------------------------------------------------
// frame_checker
// Watches the command stream, the frame byte stream and the register port of
// the seven-segment text frame writer. It keeps its own copy of the digit
// buffer, cursor and registers, works out the frame bytes every accepted
// command should produce and compares each byte transaction with the oldest
// one still due.
// ----------------------------------------------------------------------------
module frame_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // char_code, first_char, start_pos
  input  logic [sstfw_pkg::CMD_W-1:0]   s_axis_tuser,  // command
  input  logic                          s_axis_tlast,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [7:0]                    m_axis_tdata,  // bus_byte
  input  logic [1:0]                    m_axis_tuser,  // start_before, stop_after
  input  logic                          m_axis_tlast,
  input  logic                          cfg_we,
  input  logic [sstfw_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [sstfw_pkg::CFG_DW-1:0]  cfg_data,
  output int                            mismatches,
  output int                            bytes_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import sstfw_pkg::*;

  localparam int DIGITS = DIGITS_DEFAULT;

  localparam logic [7:0] SEGMENTS [17] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f,
    8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71, 8'hff
  };

  typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       frame_end;
  } frame_byte_t;

  frame_byte_t frame_bytes_due[$];

  logic [7:0]  seg_buf [DIGITS];
  logic [3:0]  cur_pos;
  logic [3:0]  disp_ctrl;
  logic [31:0] remap_reg;
  logic [7:0]  dot_bits;
  logic [7:0]  data_cmd;
  logic [7:0]  addr_cmd;
  logic [7:0]  ctrl_cmd;

  function automatic logic [7:0] segments_for(input logic [7:0] code);
    int idx;
    idx = code;
    if (code >= "0" && code <= "9") begin
      return SEGMENTS[idx - 48];
    end
    if (code >= "A" && code <= "Z") begin
      idx = idx + 32;
    end
    idx = idx - 87;
    if (idx > 16) idx = 16;
    if (idx < 0) idx = 0;
    return SEGMENTS[idx];
  endfunction

  function automatic logic [3:0] slot_for(input logic [3:0] pos);
    logic [31:0] shifted;
    shifted = remap_reg >> (4 * pos[2:0]);
    return shifted[3:0];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic st, input logic sp,
                           input logic fe);
    frame_byte_t fb;
    fb.bus_byte     = b;
    fb.start_before = st;
    fb.stop_after   = sp;
    fb.frame_end    = fe;
    frame_bytes_due.push_back(fb);
  endtask

  task automatic queue_frame();
    int i;
    push_byte(data_cmd, 1'b1, 1'b1, 1'b0);
    push_byte(addr_cmd, 1'b1, 1'b0, 1'b0);
    for (i = 0; i < DIGITS; i++) begin
      push_byte(seg_buf[i], 1'b0, i == DIGITS - 1, 1'b0);
    end
    push_byte(ctrl_cmd + {4'h0, disp_ctrl}, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [7:0] code,
                                 input logic first, input logic [3:0] start,
                                 input logic last);
    logic [3:0] slot;
    int i;
    case (cmd)
      CMD_PUT: begin
        if (first) cur_pos = start;
        if (cur_pos < DIGITS) begin
          if (code == CHAR_PERIOD) begin
            // dot goes on the digit before the cursor; nothing at position zero
            if (cur_pos != 4'd0) begin
              slot = slot_for(cur_pos - 4'd1);
              if (slot < DIGITS) seg_buf[slot] = seg_buf[slot] | dot_bits;
            end
          end else begin
            slot = slot_for(cur_pos);
            if (slot < DIGITS) seg_buf[slot] = segments_for(code);
            cur_pos = cur_pos + 4'd1;
          end
        end
        if (last) queue_frame();
      end
      CMD_CLEAR: begin
        for (i = 0; i < DIGITS; i++) seg_buf[i] = 8'h00;
        queue_frame();
      end
      CMD_REFRESH: begin
        queue_frame();
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches = mismatches + 1;
    $display("%0t ns: frame byte mismatch on %s: got %02h, expected %02h",
             $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    int i;
    if (rst) begin
      for (i = 0; i < DIGITS; i++) seg_buf[i] = 8'h00;
      cur_pos   = 4'd0;
      disp_ctrl = RST_DISPLAY_CONTROL;
      remap_reg = RST_POSITION_REMAP;
      dot_bits  = RST_DOT_MASK;
      data_cmd  = RST_DATA_COMMAND;
      addr_cmd  = RST_ADDRESS_COMMAND;
      ctrl_cmd  = RST_CONTROL_COMMAND;
      frame_bytes_due.delete();
    end else begin
      // output first: a byte leaving now belongs to an earlier command
      if (m_axis_tvalid && m_axis_tready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata, 8'h00);
        end else begin
          want = frame_bytes_due.pop_front();
          if (m_axis_tdata !== want.bus_byte)
            report_mismatch("bus_byte", m_axis_tdata, want.bus_byte);
          if (m_axis_tuser[0] !== want.start_before)
            report_mismatch("start_before", {7'd0, m_axis_tuser[0]}, {7'd0, want.start_before});
          if (m_axis_tuser[1] !== want.stop_after)
            report_mismatch("stop_after", {7'd0, m_axis_tuser[1]}, {7'd0, want.stop_after});
          if (m_axis_tlast !== want.frame_end)
            report_mismatch("frame_end", {7'd0, m_axis_tlast}, {7'd0, want.frame_end});
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DISPLAY_CONTROL: disp_ctrl = cfg_data[3:0];
          REG_POSITION_REMAP:  remap_reg = cfg_data[31:0];
          REG_DOT_MASK:        dot_bits  = cfg_data[7:0];
          REG_DATA_COMMAND:    data_cmd  = cfg_data[7:0];
          REG_ADDRESS_COMMAND: addr_cmd  = cfg_data[7:0];
          REG_CONTROL_COMMAND: ctrl_cmd  = cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_command(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                        s_axis_tdata[12:9], s_axis_tlast);
      end
    end
    bytes_due <= frame_bytes_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the seven-segment text frame writer with a directed set of commands
// and then random strings, clears, refreshes and noise under several register
// settings and three idling patterns. Frame bytes are checked by
// frame_checker; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sstfw_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = DIGITS_DEFAULT + 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TEXT_QUOTA     = 15;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;  // char_code, first_char, start_pos
  logic [CMD_W-1:0]  s_axis_tuser = CMD_PUT;  // command
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;  // bus_byte
  logic [1:0]        m_axis_tuser;  // start_before, stop_after
  logic              m_axis_tlast;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = REG_DISPLAY_CONTROL;
  logic [CFG_DW-1:0] cfg_data = '0;

  int mismatches;
  int bytes_due;
  int feed_gap_pct = 21;
  int sink_stall_pct = 61;
  int items_sent = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  seven_segment_text_frame_writer dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  frame_checker frame_check (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data,
    .mismatches, .bytes_due
  );

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // nothing moving for too long means a hang
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [7:0] code,
                              input logic first, input logic [3:0] start,
                              input logic last);
    if ($urandom_range(0, 99) < feed_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < feed_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, start, first, code};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input int k);
    logic [31:0] remap;
    int p;
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    case (k)
      0: begin
        write_reg(REG_DISPLAY_CONTROL, 32'(RST_DISPLAY_CONTROL));
        write_reg(REG_POSITION_REMAP,  RST_POSITION_REMAP);
        write_reg(REG_DOT_MASK,        32'(RST_DOT_MASK));
        write_reg(REG_DATA_COMMAND,    32'(RST_DATA_COMMAND));
        write_reg(REG_ADDRESS_COMMAND, 32'(RST_ADDRESS_COMMAND));
        write_reg(REG_CONTROL_COMMAND, 32'(RST_CONTROL_COMMAND));
      end
      1: begin
        write_reg(REG_DISPLAY_CONTROL, 32'h0);
        write_reg(REG_POSITION_REMAP,  32'h0);
        write_reg(REG_DOT_MASK,        32'h0);
        write_reg(REG_DATA_COMMAND,    32'h0);
        write_reg(REG_ADDRESS_COMMAND, 32'h0);
        write_reg(REG_CONTROL_COMMAND, 32'h0);
      end
      2: begin
        write_reg(REG_DISPLAY_CONTROL, 32'hf);
        write_reg(REG_POSITION_REMAP,  32'hffff_ffff);
        write_reg(REG_DOT_MASK,        32'hff);
        write_reg(REG_DATA_COMMAND,    32'hff);
        write_reg(REG_ADDRESS_COMMAND, 32'hff);
        write_reg(REG_CONTROL_COMMAND, 32'hff);
      end
      default: begin
        // mostly in-range slots, now and then one out of range (6 to 15)
        for (p = 0; p < 8; p++) begin
          remap[4*p +: 4] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(6, 15))
                                                          : 4'($urandom_range(0, 5));
        end
        write_reg(REG_DISPLAY_CONTROL, 32'($urandom_range(0, 15)));
        write_reg(REG_POSITION_REMAP,  remap);
        write_reg(REG_DOT_MASK,        32'($urandom_range(0, 255)));
        write_reg(REG_DATA_COMMAND,    32'($urandom_range(0, 255)));
        write_reg(REG_ADDRESS_COMMAND, 32'($urandom_range(0, 255)));
        write_reg(REG_CONTROL_COMMAND, 32'($urandom_range(0, 255)));
      end
    endcase
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 8'($urandom_range(8'h30, 8'h39));
    if (r < 45) return 8'($urandom_range(8'h61, 8'h66));
    if (r < 55) return 8'($urandom_range(8'h41, 8'h46));
    if (r < 70) return CHAR_PERIOD;
    if (r < 80) return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h67, 8'h7a))
                                                    : 8'($urandom_range(8'h47, 8'h5a));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic run_text(input int quota);
    int first_item;
    int len;
    int r;
    int i;
    logic [3:0] sp;
    first_item = items_sent;
    while (items_sent - first_item < quota) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_command(CMD_CLEAR, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      end else if (r < 12) begin
        send_command(CMD_REFRESH, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      end else if (r < 15) begin
        send_command(CMD_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      end else if (r < 22) begin
        send_command(CMD_PUT, 8'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      end else begin
        len = $urandom_range(1, 8);
        sp = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 5));
        for (i = 0; i < len; i++) begin
          send_command(CMD_PUT, pick_char(), i == 0, (i == 0) ? sp : 4'($urandom),
                       i == len - 1);
        end
      end
    end
  endtask

  initial begin
    int ph;
    int s;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset frame, glyph extremes, dots, ignored cursor, flag handling
    send_command(CMD_REFRESH, 8'h00, 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, CHAR_PERIOD, 1'b1, 4'd0, 1'b0);
    send_command(CMD_PUT, "0", 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, CHAR_PERIOD, 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, "9", 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, "A", 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, "f", 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, "g", 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, 8'hff, 1'b0, 4'd0, 1'b1);
    send_command(CMD_PUT, "Z", 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, CHAR_PERIOD, 1'b0, 4'd0, 1'b1);
    send_command(CMD_PUT, 8'h00, 1'b1, 4'd15, 1'b1);
    send_command(CMD_PUT, "a", 1'b1, 4'd8, 1'b0);
    send_command(CMD_UNUSED, 8'hff, 1'b1, 4'd15, 1'b1);
    send_command(CMD_REFRESH, 8'hff, 1'b1, 4'd3, 1'b1);
    send_command(CMD_PUT, 8'h80, 1'b1, 4'd2, 1'b0);
    send_command(CMD_PUT, 8'h5b, 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, "z", 1'b0, 4'd0, 1'b0);
    send_command(CMD_PUT, CHAR_PERIOD, 1'b0, 4'd0, 1'b1);
    send_command(CMD_CLEAR, 8'hff, 1'b1, 4'd15, 1'b1);
    send_command(CMD_PUT, 8'h5f, 1'b1, 4'd5, 1'b1);
    send_command(CMD_PUT, 8'h56, 1'b1, 4'd4, 1'b0);
    send_command(CMD_PUT, 8'h7f, 1'b0, 4'd0, 1'b1);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin feed_gap_pct <= 21; sink_stall_pct <= 61; end
        1: begin feed_gap_pct <= 61; sink_stall_pct <= 21; end
        default: begin feed_gap_pct <= 0; sink_stall_pct <= 0; end
      endcase
      for (s = 0; s < 3; s++) begin
        apply_setting(ph * 3 + s);
        run_text(TEXT_QUOTA);
        if (s == 1) hold_until_drained();
        run_text(TEXT_QUOTA);
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && bytes_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sstfw_pkg.sv
rtl/core/seven_segment_text_frame_writer.sv
tb/frame_checker.sv
tb/testbench.sv
